// File: design/sspes_pkg.sv
// ----------------------------------------------------------------------------
// sspes_pkg
// Shared types, constants and the sector table of the single shunt edge
// shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package sspes_pkg;

  localparam int unsigned DutyFracBitsDef = 15;
  localparam int unsigned NumStages       = 6;
  localparam int unsigned RegWidth        = 12;

  localparam logic [RegWidth-1:0] MinWindowRst = 12'd100;
  localparam logic [RegWidth-1:0] TrigDelayRst = 12'd80;

  typedef enum logic {
    RegMinWindow = 1'b0,
    RegTrigDelay = 1'b1
  } reg_idx_e;

  localparam logic [1:0] PhaseU = 2'd0;
  localparam logic [1:0] PhaseV = 2'd1;
  localparam logic [1:0] PhaseW = 2'd2;

  localparam logic [2:0] SectNullLo = 3'd0;
  localparam logic [2:0] SectNullHi = 3'd7;

  typedef struct packed {
    logic [NumStages-1:0] ld;
  } pipe_ld_t;

  typedef struct packed {
    logic [2:0] sect;
    logic [1:0] minp;
    logic [1:0] medp;
    logic [1:0] maxp;
  } sect_entry_t;

  typedef struct packed {
    logic [15:0] second_trigger;
    logic [15:0] first_trigger;
    logic [1:0]  min_phase;
    logic [1:0]  med_phase;
    logic [1:0]  max_phase;
    logic [2:0]  sector;
    logic [15:0] fall_w;
    logic [15:0] fall_v;
    logic [15:0] fall_u;
    logic [15:0] rise_w;
    logic [15:0] rise_v;
    logic [15:0] rise_u;
  } out_item_t;

  // index = (u > v, w > u, v > w)
  function automatic sect_entry_t sect_lookup(input logic [2:0] idx);
    sect_entry_t e;
    case (idx)
      3'd0:    e = '{sect: 3'd0, minp: PhaseU, medp: PhaseV, maxp: PhaseW};
      3'd1:    e = '{sect: 3'd2, minp: PhaseW, medp: PhaseU, maxp: PhaseV};
      3'd2:    e = '{sect: 3'd4, minp: PhaseU, medp: PhaseV, maxp: PhaseW};
      3'd3:    e = '{sect: 3'd3, minp: PhaseU, medp: PhaseW, maxp: PhaseV};
      3'd4:    e = '{sect: 3'd6, minp: PhaseV, medp: PhaseW, maxp: PhaseU};
      3'd5:    e = '{sect: 3'd1, minp: PhaseW, medp: PhaseV, maxp: PhaseU};
      3'd6:    e = '{sect: 3'd5, minp: PhaseV, medp: PhaseU, maxp: PhaseW};
      default: e = '{sect: 3'd7, minp: PhaseU, medp: PhaseV, maxp: PhaseW};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: design/sspes_lane.sv
// ----------------------------------------------------------------------------
// sspes_lane
// One phase lane: saturates the duty and turns it into a timer compare value
// over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sspes_lane import sspes_pkg::*; #(
  parameter int unsigned DUTY_FRAC_BITS = DutyFracBitsDef
) (
  input  logic        clk_i,
  input  pipe_ld_t    ld_i,
  input  logic [15:0] duty_i,
  input  logic [15:0] period_i,
  output logic [15:0] orig_o
);

  localparam logic [16:0] Full = 17'(1) << DUTY_FRAC_BITS;

  logic [16:0] sat;
  logic [32:0] prod_d, prod_q;
  logic [15:0] period_q;
  logic [15:0] orig_q;

  assign sat    = ({1'b0, duty_i} > Full) ? Full : {1'b0, duty_i};
  assign prod_d = {16'd0, sat} * {17'd0, period_i};

  always_ff @(posedge clk_i) begin
    if (ld_i.ld[0]) begin
      prod_q   <= prod_d;
      period_q <= period_i;
    end
    if (ld_i.ld[1]) begin
      orig_q <= period_q - prod_q[DUTY_FRAC_BITS +: 16];
    end
  end

  assign orig_o = orig_q;

endmodule

`default_nettype wire

// File: design/sspes_merge.sv
// ----------------------------------------------------------------------------
// sspes_merge
// Sector decode, star area clamp, edge shifting and trigger points; combines
// the three lane compare values into one result item.
// ----------------------------------------------------------------------------
`default_nettype none

module sspes_merge import sspes_pkg::*; (
  input  logic                clk_i,
  input  pipe_ld_t            ld_i,
  input  logic [15:0]         duty_u_i,
  input  logic [15:0]         duty_v_i,
  input  logic [15:0]         duty_w_i,
  input  logic [15:0]         period_i,
  input  logic [15:0]         orig_u_i,
  input  logic [15:0]         orig_v_i,
  input  logic [15:0]         orig_w_i,
  input  logic [RegWidth-1:0] min_window_i,
  input  logic [RegWidth-1:0] trig_delay_i,
  output out_item_t           item_o
);

  function automatic logic [15:0] pick(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c, input logic [1:0] sel);
    logic [15:0] r;
    case (sel)
      PhaseU:  r = a;
      PhaseV:  r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] place(input logic [1:0] p, input sect_entry_t e,
                                        input logic [15:0] vmax, input logic [15:0] vmed,
                                        input logic [15:0] vmin);
    logic [15:0] r;
    if (e.maxp == p) begin
      r = vmax;
    end else if (e.medp == p) begin
      r = vmed;
    end else begin
      r = vmin;
    end
    return r;
  endfunction

  // stage 1: compares
  logic [2:0]  idx_q;
  logic [15:0] period1_q;
  // stage 2: table and limits
  sect_entry_t ent2_q;
  logic [15:0] limit_q, p2w_q;
  // stage 3: clamp
  sect_entry_t ent3_q;
  logic        null3_q;
  logic [15:0] cmax3_q, cmed3_q, cmin3_q;
  // stage 4: deltas
  sect_entry_t ent4_q;
  logic        null4_q;
  logic [15:0] cmax4_q, cmed4_q, cmin4_q, dmax_q, dmin_q;
  // stage 5: shifted edges
  sect_entry_t ent5_q;
  logic [15:0] rmax_q, fmax_q, med5_q, rmin_q, fmin_q;
  // stage 6: result
  out_item_t   item_q;

  logic        null3_d;
  logic [15:0] omax, omed, omin;
  logic [15:0] cmax3_d, cmed3_d;
  logic        lo_max, lo_min;
  logic [RegWidth-1:0] smax, smin;
  logic [15:0] rmax_d, fmax_d, rmin_d, fmin_d;
  logic [15:0] rise_u, rise_v, rise_w;

  assign null3_d = (ent2_q.sect == SectNullLo) || (ent2_q.sect == SectNullHi);
  assign omax    = pick(orig_u_i, orig_v_i, orig_w_i, ent2_q.maxp);
  assign omed    = pick(orig_u_i, orig_v_i, orig_w_i, ent2_q.medp);
  assign omin    = pick(orig_u_i, orig_v_i, orig_w_i, ent2_q.minp);

  always_comb begin
    cmax3_d = omax;
    cmed3_d = omed;
    if (!null3_d) begin
      if (omax > limit_q) begin
        cmax3_d = p2w_q;
        cmed3_d = limit_q;
      end else if (omed > limit_q) begin
        cmed3_d = limit_q;
      end
    end
  end

  assign lo_max = dmax_q < {4'd0, min_window_i};
  assign lo_min = dmin_q < {4'd0, min_window_i};
  assign smax   = min_window_i - dmax_q[RegWidth-1:0];
  assign smin   = min_window_i - dmin_q[RegWidth-1:0];

  always_comb begin
    rmax_d = cmax4_q;
    fmax_d = cmax4_q;
    rmin_d = cmin4_q;
    fmin_d = cmin4_q;
    if (!null4_q && lo_max) begin
      rmax_d = cmax4_q - {4'd0, smax};
      fmax_d = cmax4_q + {4'd0, smax};
    end
    if (!null4_q && lo_min) begin
      rmin_d = cmin4_q + {4'd0, smin};
      fmin_d = cmin4_q - {4'd0, smin};
    end
  end

  assign rise_u = place(PhaseU, ent5_q, rmax_q, med5_q, rmin_q);
  assign rise_v = place(PhaseV, ent5_q, rmax_q, med5_q, rmin_q);
  assign rise_w = place(PhaseW, ent5_q, rmax_q, med5_q, rmin_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.ld[0]) begin
      idx_q     <= {duty_u_i > duty_v_i, duty_w_i > duty_u_i, duty_v_i > duty_w_i};
      period1_q <= period_i;
    end
    if (ld_i.ld[1]) begin
      ent2_q  <= sect_lookup(idx_q);
      limit_q <= period1_q - {4'd0, min_window_i};
      p2w_q   <= period1_q - {3'd0, min_window_i, 1'b0};
    end
    if (ld_i.ld[2]) begin
      ent3_q  <= ent2_q;
      null3_q <= null3_d;
      cmax3_q <= cmax3_d;
      cmed3_q <= cmed3_d;
      cmin3_q <= omin;
    end
    if (ld_i.ld[3]) begin
      ent4_q  <= ent3_q;
      null4_q <= null3_q;
      cmax4_q <= cmax3_q;
      cmed4_q <= cmed3_q;
      cmin4_q <= cmin3_q;
      dmax_q  <= cmed3_q - cmax3_q;
      dmin_q  <= cmin3_q - cmed3_q;
    end
    if (ld_i.ld[4]) begin
      ent5_q <= ent4_q;
      rmax_q <= rmax_d;
      fmax_q <= fmax_d;
      med5_q <= cmed4_q;
      rmin_q <= rmin_d;
      fmin_q <= fmin_d;
    end
    if (ld_i.ld[5]) begin
      item_q.rise_u         <= rise_u;
      item_q.rise_v         <= rise_v;
      item_q.rise_w         <= rise_w;
      item_q.fall_u         <= place(PhaseU, ent5_q, fmax_q, med5_q, fmin_q);
      item_q.fall_v         <= place(PhaseV, ent5_q, fmax_q, med5_q, fmin_q);
      item_q.fall_w         <= place(PhaseW, ent5_q, fmax_q, med5_q, fmin_q);
      item_q.sector         <= ent5_q.sect;
      item_q.max_phase      <= ent5_q.maxp;
      item_q.med_phase      <= ent5_q.medp;
      item_q.min_phase      <= ent5_q.minp;
      item_q.first_trigger  <= rmax_q + {4'd0, trig_delay_i};
      item_q.second_trigger <= med5_q + {4'd0, trig_delay_i};
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// File: design/single_shunt_pwm_edge_shifter_core.sv
// ----------------------------------------------------------------------------
// single_shunt_pwm_edge_shifter_core
// Turns three phase duties and a timer period into shifted rise and fall
// compare values, the sector and two ADC trigger points.
// ----------------------------------------------------------------------------
// Takes one item per clock and passes it through six register stages (one
// multiplier per phase lane, then sector decode, clamp, deltas, edge shift
// and trigger add). Each stage stalls only when the stage after it is full,
// so throughput stays one item per cycle as long as the result side takes
// items.
`default_nettype none

module single_shunt_pwm_edge_shifter_core import sspes_pkg::*; #(
  parameter int unsigned DUTY_FRAC_BITS = DutyFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // duty_u, duty_v, duty_w, pwm_period
  input  logic [63:0]         s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // rise_u, rise_v, rise_w, fall_u, fall_v, fall_w, sector, max_phase,
  // med_phase, min_phase, first_trigger, second_trigger, zero fill
  output logic [143:0]        m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [RegWidth-1:0] cfg_wdata_i
);

  logic [RegWidth-1:0]  min_window_q, trig_delay_q;
  logic [NumStages-1:0] valid_q, valid_d, prev_valid;
  pipe_ld_t             ld;
  logic [15:0]          orig_u, orig_v, orig_w;
  out_item_t            item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_window_q <= MinWindowRst;
      trig_delay_q <= TrigDelayRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegMinWindow: min_window_q <= cfg_wdata_i;
        RegTrigDelay: trig_delay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign prev_valid = {valid_q[NumStages-2:0], s_axis_tvalid_i};

  always_comb begin
    ld.ld[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ld.ld[k] = !valid_q[k] || ld.ld[k+1];
    end
    for (int k = 0; k < NumStages; k++) begin
      valid_d[k] = ld.ld[k] ? prev_valid[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  sspes_lane #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_lane_u (
    .clk_i(clk_i), .ld_i(ld), .duty_i(s_axis_tdata_i[15:0]),
    .period_i(s_axis_tdata_i[63:48]), .orig_o(orig_u)
  );

  sspes_lane #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_lane_v (
    .clk_i(clk_i), .ld_i(ld), .duty_i(s_axis_tdata_i[31:16]),
    .period_i(s_axis_tdata_i[63:48]), .orig_o(orig_v)
  );

  sspes_lane #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_lane_w (
    .clk_i(clk_i), .ld_i(ld), .duty_i(s_axis_tdata_i[47:32]),
    .period_i(s_axis_tdata_i[63:48]), .orig_o(orig_w)
  );

  sspes_merge u_merge (
    .clk_i        (clk_i),
    .ld_i         (ld),
    .duty_u_i     (s_axis_tdata_i[15:0]),
    .duty_v_i     (s_axis_tdata_i[31:16]),
    .duty_w_i     (s_axis_tdata_i[47:32]),
    .period_i     (s_axis_tdata_i[63:48]),
    .orig_u_i     (orig_u),
    .orig_v_i     (orig_v),
    .orig_w_i     (orig_w),
    .min_window_i (min_window_q),
    .trig_delay_i (trig_delay_q),
    .item_o       (item)
  );

  assign s_axis_tready_o = ld.ld[0];
  assign m_axis_tvalid_o = valid_q[NumStages-1];
  assign m_axis_tdata_o  = {7'd0, item};

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&valid_q))
    else $error("input stalled with a free pipeline stage");

  a_roles_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (item.max_phase != item.med_phase) &&
                        (item.med_phase != item.min_phase) &&
                        (item.max_phase != item.min_phase))
    else $error("phase roles not a permutation");

  a_null_no_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((item.sector == SectNullLo) || (item.sector == SectNullHi)) |->
      (item.rise_u == item.fall_u) && (item.rise_v == item.fall_v) &&
      (item.rise_w == item.fall_w))
    else $error("null sector item has shifted edges");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NumStages-1] && !m_axis_tready_i |=> valid_q[NumStages-1] && $stable(item))
    else $error("pending result changed while stalled");

endmodule

`default_nettype wire

// File: dv/edge_shift_checker.sv
// ----------------------------------------------------------------------------
// edge_shift_checker
// Watches the input, result and register write ports of the edge shifter,
// works out the shifted compare values, sector, phase order and trigger
// points of every accepted item, and compares each result field by field in
// arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_shift_checker import sspes_pkg::*; #(
  parameter int unsigned DUTY_FRAC_BITS = DutyFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [63:0]         s_data_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [143:0]        m_data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [RegWidth-1:0] cfg_wdata_i,
  output int unsigned         pending_o,
  output int unsigned         fail_cnt_o
);

  out_item_t     expected_edges_q[$];
  logic [11:0]   win_q = MinWindowRst;
  logic [11:0]   dly_q = TrigDelayRst;
  int unsigned   n_fail = 0;

  function automatic out_item_t shift_edges(input logic [15:0] duty_u, duty_v, duty_w,
                                            input logic [15:0] period,
                                            input logic [11:0] win, dly);
    logic [15:0] duty [3];
    logic [15:0] orig [3];
    logic [15:0] comp [3];
    logic [15:0] rise [3];
    logic [15:0] fall [3];
    logic [15:0] w16, limit, dmax, dmin, sh;
    logic [31:0] full, sat, on;
    logic [2:0]  sel, sect;
    logic [1:0]  pmax, pmed, pmin;
    out_item_t   r;
    int          i;
    duty[0] = duty_u;
    duty[1] = duty_v;
    duty[2] = duty_w;
    full = 32'd1 << DUTY_FRAC_BITS;
    w16 = {4'd0, win};
    for (i = 0; i < 3; i++) begin
      sat = ({16'd0, duty[i]} > full) ? full : {16'd0, duty[i]};
      on = (sat * {16'd0, period}) >> DUTY_FRAC_BITS;
      orig[i] = period - on[15:0];
    end
    sel = {duty[0] > duty[1], duty[2] > duty[0], duty[1] > duty[2]};
    case (sel)
      3'd0:    begin sect = 3'd0; pmin = PhaseU; pmed = PhaseV; pmax = PhaseW; end
      3'd1:    begin sect = 3'd2; pmin = PhaseW; pmed = PhaseU; pmax = PhaseV; end
      3'd2:    begin sect = 3'd4; pmin = PhaseU; pmed = PhaseV; pmax = PhaseW; end
      3'd3:    begin sect = 3'd3; pmin = PhaseU; pmed = PhaseW; pmax = PhaseV; end
      3'd4:    begin sect = 3'd6; pmin = PhaseV; pmed = PhaseW; pmax = PhaseU; end
      3'd5:    begin sect = 3'd1; pmin = PhaseW; pmed = PhaseV; pmax = PhaseU; end
      3'd6:    begin sect = 3'd5; pmin = PhaseV; pmed = PhaseU; pmax = PhaseW; end
      default: begin sect = 3'd7; pmin = PhaseU; pmed = PhaseV; pmax = PhaseW; end
    endcase
    if (sect != SectNullLo && sect != SectNullHi) begin
      limit = period - w16;
      // star area clamp
      if (orig[pmax] > limit) begin
        comp[pmax] = period - (w16 << 1);
        comp[pmed] = limit;
      end else if (orig[pmed] > limit) begin
        comp[pmax] = orig[pmax];
        comp[pmed] = limit;
      end else begin
        comp[pmax] = orig[pmax];
        comp[pmed] = orig[pmed];
      end
      comp[pmin] = orig[pmin];
      dmax = comp[pmed] - comp[pmax];
      dmin = comp[pmin] - comp[pmed];
      rise[pmed] = comp[pmed];
      fall[pmed] = comp[pmed];
      if (dmax < w16) begin
        sh = w16 - dmax;
        rise[pmax] = comp[pmax] - sh;
        fall[pmax] = comp[pmax] + sh;
      end else begin
        rise[pmax] = comp[pmax];
        fall[pmax] = comp[pmax];
      end
      if (dmin < w16) begin
        sh = w16 - dmin;
        rise[pmin] = comp[pmin] + sh;
        fall[pmin] = comp[pmin] - sh;
      end else begin
        rise[pmin] = comp[pmin];
        fall[pmin] = comp[pmin];
      end
    end else begin
      for (i = 0; i < 3; i++) begin
        rise[i] = orig[i];
        fall[i] = orig[i];
      end
    end
    r = '0;
    r.rise_u         = rise[0];
    r.rise_v         = rise[1];
    r.rise_w         = rise[2];
    r.fall_u         = fall[0];
    r.fall_v         = fall[1];
    r.fall_w         = fall[2];
    r.sector         = sect;
    r.max_phase      = pmax;
    r.med_phase      = pmed;
    r.min_phase      = pmin;
    r.first_trigger  = rise[pmax] + {4'd0, dly};
    r.second_trigger = rise[pmed] + {4'd0, dly};
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want, got;
    if (!rst_ni) begin
      win_q = MinWindowRst;
      dly_q = TrigDelayRst;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = out_item_t'(m_data_i[$bits(out_item_t)-1:0]);
        if (expected_edges_q.size() == 0) begin
          n_fail++;
          $display("%0t: result with none expected, got %h", $time, got);
        end else begin
          want = expected_edges_q.pop_front();
          check_field("rise_u", want.rise_u, got.rise_u);
          check_field("rise_v", want.rise_v, got.rise_v);
          check_field("rise_w", want.rise_w, got.rise_w);
          check_field("fall_u", want.fall_u, got.fall_u);
          check_field("fall_v", want.fall_v, got.fall_v);
          check_field("fall_w", want.fall_w, got.fall_w);
          check_field("sector", 16'(want.sector), 16'(got.sector));
          check_field("max_phase", 16'(want.max_phase), 16'(got.max_phase));
          check_field("med_phase", 16'(want.med_phase), 16'(got.med_phase));
          check_field("min_phase", 16'(want.min_phase), 16'(got.min_phase));
          check_field("first_trigger", want.first_trigger, got.first_trigger);
          check_field("second_trigger", want.second_trigger, got.second_trigger);
        end
      end
      if (s_valid_i && s_ready_i)
        expected_edges_q.push_back(shift_edges(s_data_i[15:0], s_data_i[31:16],
                                               s_data_i[47:32], s_data_i[63:48],
                                               win_q, dly_q));
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegMinWindow: win_q = cfg_wdata_i;
          RegTrigDelay: dly_q = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o  = expected_edges_q.size();
    fail_cnt_o = n_fail;
  end

endmodule

`default_nettype wire

// File: dv/tb_single_shunt_pwm_edge_shifter_core.sv
// ----------------------------------------------------------------------------
// tb_single_shunt_pwm_edge_shifter_core
// Drives directed and random duty/period items into the edge shifter under
// several window and trigger delay settings, with random gaps on both
// streams and long result-side hold-offs; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_single_shunt_pwm_edge_shifter_core;
  import sspes_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned SqueezeLen  = 150;
  localparam logic [15:0] FullDuty    = 16'd32768;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // duty_u, duty_v, duty_w, pwm_period
  logic [63:0]         s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // rise_u, rise_v, rise_w, fall_u, fall_v, fall_w, sector, max_phase,
  // med_phase, min_phase, first_trigger, second_trigger, zero fill
  logic [143:0]        m_axis_tdata_o;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [RegWidth-1:0] cfg_wdata_i;

  int unsigned n_pending;
  int unsigned n_fail;
  int unsigned stall_cycles = 0;
  bit          squeeze_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  single_shunt_pwm_edge_shifter_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  edge_shift_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_i   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .m_valid_i   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_i    (m_axis_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (n_pending),
    .fail_cnt_o  (n_fail)
  );

  function automatic logic [63:0] pack_item(input logic [15:0] du, dv, dw, per);
    return {per, dw, dv, du};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_duty();
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [63:0] rand_item(input logic [11:0] win);
    int unsigned mode, which;
    int          base, spread, v [3];
    logic [15:0] d [3];
    logic [15:0] per;
    mode = $urandom_range(0, 99);
    per = 16'($urandom());
    if (mode < 35) begin
      d[0] = rand_duty();
      d[1] = rand_duty();
      d[2] = rand_duty();
    end else if (mode < 60) begin
      // duties close together so edges need shifting
      base = int'($urandom_range(0, 32768));
      spread = int'($urandom_range(0, 1500));
      for (int i = 0; i < 3; i++) begin
        v[i] = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v[i] < 0) v[i] = 0;
        if (v[i] > 32768) v[i] = 32768;
        d[i] = 16'(v[i]);
      end
    end else if (mode < 72) begin
      // short period, wraps below the window
      per = 16'($urandom_range(0, 2 * win + 50));
      d[0] = rand_duty();
      d[1] = rand_duty();
      d[2] = rand_duty();
    end else if (mode < 85) begin
      d[0] = 16'($urandom());
      d[1] = 16'($urandom());
      d[2] = 16'($urandom());
    end else begin
      // ties
      case ($urandom_range(0, 2))
        0:       base = 0;
        1:       base = 32768;
        default: base = int'($urandom_range(0, 32768));
      endcase
      d[0] = 16'(base);
      d[1] = 16'(base);
      d[2] = 16'(base);
      which = $urandom_range(0, 3);
      if (which != 0) d[which - 1] = rand_duty();
    end
    return pack_item(d[0], d[1], d[2], per);
  endfunction

  task automatic offer(input logic [63:0] item);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= item;
    do @(posedge clk_i); while (!s_axis_tready_o);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (n_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [11:0] win, dly);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegMinWindow;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_idx_i   <= RegTrigDelay;
    cfg_wdata_i <= dly;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // result side: random stalls, long runs, and hold-offs on request
  initial begin : result_sink
    int unsigned run_len, gap_len;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                            : $urandom_range(1, 8);
      m_axis_tready_i <= 1'b1;
      repeat (run_len) begin
        @(posedge clk_i);
        if (squeeze_req) break;
      end
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        gap_len = SqueezeLen;
      end else begin
        gap_len = pick_gap();
      end
      if (gap_len != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no item accepted for %0d cycles", $time, StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [63:0] directed_q[$];
    logic [11:0] win_set [NumPhases];
    logic [11:0] dly_set [NumPhases];
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegMinWindow;
    cfg_wdata_i     = '0;
    win_set = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'($urandom()), 12'($urandom())};
    dly_set = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'($urandom()), 12'($urandom())};

    directed_q.push_back(pack_item(16'd0, 16'd0, 16'd0, 16'd1000));
    directed_q.push_back(pack_item(FullDuty, FullDuty, FullDuty, 16'hFFFF));
    directed_q.push_back(pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_q.push_back(pack_item(16'd40000, 16'd1000, 16'd20000, 16'd50000));
    directed_q.push_back(pack_item(16'd32769, FullDuty, 16'd0, 16'd30000));
    // one item per active sector
    directed_q.push_back(pack_item(16'd30000, 16'd20000, 16'd10000, 16'd20000));
    directed_q.push_back(pack_item(16'd20000, 16'd30000, 16'd10000, 16'd20000));
    directed_q.push_back(pack_item(16'd10000, 16'd30000, 16'd20000, 16'd20000));
    directed_q.push_back(pack_item(16'd10000, 16'd20000, 16'd30000, 16'd20000));
    directed_q.push_back(pack_item(16'd20000, 16'd10000, 16'd30000, 16'd20000));
    directed_q.push_back(pack_item(16'd30000, 16'd10000, 16'd20000, 16'd20000));
    // close edges, star area, wrap, period extremes
    directed_q.push_back(pack_item(16'd16000, 16'd16050, 16'd15950, 16'd20000));
    directed_q.push_back(pack_item(16'd100, 16'd50, 16'd10, 16'd1000));
    directed_q.push_back(pack_item(16'd30000, 16'd50, 16'd10, 16'd1000));
    directed_q.push_back(pack_item(16'd20000, 16'd100, 16'd50, 16'd150));
    directed_q.push_back(pack_item(16'd10000, 16'd20000, 16'd30000, 16'd0));
    directed_q.push_back(pack_item(FullDuty, 16'd0, 16'd16384, 16'hFFFF));
    directed_q.push_back(pack_item(16'd0, 16'd0, FullDuty, 16'hFFFF));
    // pairwise ties and a three-way tie
    directed_q.push_back(pack_item(16'd20000, 16'd20000, 16'd10000, 16'd40000));
    directed_q.push_back(pack_item(16'd10000, 16'd20000, 16'd20000, 16'd40000));
    directed_q.push_back(pack_item(16'd20000, 16'd10000, 16'd20000, 16'd40000));
    directed_q.push_back(pack_item(16'd16384, 16'd16384, 16'd16384, 16'd12345));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[k]) offer(directed_q[k]);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_cfg(win_set[p], dly_set[p]);
      if (p == 1 || p == 4) squeeze_req = 1'b1;
      repeat (PhaseItems) offer(rand_item(win_set[p]));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && n_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
